// ===== hw/rtl/wehr_pkg.sv =====
package wehr_pkg;

   localparam int unsigned ROW_W         = 3;
   localparam int unsigned COL_W         = 5;
   localparam int unsigned SCAN_W        = 32;
   localparam int unsigned DEPTH_DEFAULT = 32;

   // input opcodes
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds
   localparam logic KIND_DECISION = 1'b0;
   localparam logic KIND_REPLAY   = 1'b1;

   // one held key event
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [SCAN_W-1:0] scan;
      logic              pressed;
      logic              modpress;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic key_ev;       // take a key event beat
      logic tick;         // take a scan tick beat
      logic close_pass;   // group length known, start the second pass
      logic close_group;  // retire the current group
      logic eval;         // evaluate the entry just read
      logic flush;        // send the held result as the final one
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ring_empty;
      logic at_bound;
      logic pass1;
      logic group_break;
      logic rest_empty;
   } stat_type;

endpackage

// ===== hw/rtl/wehr_ctrl.sv =====
module wehr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_opcode,
   input  logic               req_link_is_usb,
   input  logic               req_host_ready,
   input  wehr_pkg::stat_type stat,
   output wehr_pkg::cmd_type  cmd,
   output logic               busy
);
   import wehr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_opcode == OP_KEY) begin
                  cmd.key_ev = 1'b1;
               end else begin
                  cmd.tick = 1'b1;
                  if (!stat.ring_empty && req_link_is_usb && req_host_ready) begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            if (stat.at_bound) begin
               if (!stat.pass1) begin
                  cmd.close_pass = 1'b1;
               end else begin
                  cmd.close_group = 1'b1;
                  if (stat.rest_empty) begin
                     state_in = ST_FLUSH;
                  end
               end
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.group_break) begin
               cmd.close_pass = 1'b1;
            end else begin
               cmd.eval = 1'b1;
            end
            state_in = ST_READ;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/wehr_datapath.sv =====
module wehr_datapath #(
   parameter int unsigned QUEUE_DEPTH = wehr_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wehr_pkg::cmd_type            cmd,
   output wehr_pkg::stat_type           stat,
   input  logic [wehr_pkg::ROW_W-1:0]   req_key_row,
   input  logic [wehr_pkg::COL_W-1:0]   req_key_col,
   input  logic                         req_pressed,
   input  logic                         req_is_modifier,
   input  logic                         req_link_is_usb,
   input  logic                         req_host_ready,
   output logic                         rsp_strobe,
   output logic                         rsp_kind,
   output logic                         rsp_deferred,
   output logic                         rsp_overflow,
   output logic                         rsp_wake_request,
   output logic [wehr_pkg::ROW_W-1:0]   rsp_out_row,
   output logic [wehr_pkg::COL_W-1:0]   rsp_out_col,
   output logic                         rsp_out_pressed,
   output logic                         rsp_last
);
   import wehr_pkg::*;

   localparam int unsigned IW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW:0] DEPTH_S = (CW+1)'(QUEUE_DEPTH);

   entry_type mem [QUEUE_DEPTH];

   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [CW-1:0]     off_ff, off_in;
   logic [CW-1:0]     glen_ff, glen_in;
   logic [SCAN_W-1:0] gscan_ff, gscan_in;
   logic              pass_ff, pass_in;
   logic              pend_valid_ff, pend_valid_in;
   entry_type         pend_ff, pend_in;
   entry_type         rd_ff;

   logic              strobe_ff, strobe_in;
   logic              kind_ff, kind_in;
   logic              deferred_ff, deferred_in;
   logic              overflow_ff, overflow_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              pressed_ff, pressed_in;
   logic              last_ff, last_in;

   logic [CW:0]   wr_sum, rd_sum, gh_sum;
   logic [IW-1:0] wr_addr, rd_addr, gh_addr;
   logic          wr_en;
   entry_type     wr_entry;
   logic          defer, full;
   logic [CW-1:0] bound;

   // ring positions: head stays below the depth and the offsets at most at it, so one subtract wraps
   always_comb begin
      wr_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      rd_sum  = (CW+1)'(head_ff) + (CW+1)'(off_ff);
      gh_sum  = (CW+1)'(head_ff) + (CW+1)'(glen_ff);
      wr_addr = (wr_sum >= DEPTH_S) ? IW'(wr_sum - DEPTH_S) : IW'(wr_sum);
      rd_addr = (rd_sum >= DEPTH_S) ? IW'(rd_sum - DEPTH_S) : IW'(rd_sum);
      gh_addr = (gh_sum >= DEPTH_S) ? IW'(gh_sum - DEPTH_S) : IW'(gh_sum);
   end

   assign defer = req_link_is_usb && !req_host_ready;
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign bound = pass_ff ? glen_ff : count_ff;

   assign stat.ring_empty  = (count_ff == '0);
   assign stat.at_bound    = (off_ff == bound);
   assign stat.pass1       = pass_ff;
   assign stat.group_break = !pass_ff && (off_ff != '0) && (rd_ff.scan != gscan_ff);
   assign stat.rest_empty  = (count_ff == glen_ff);

   always_comb begin
      wr_entry.row      = req_key_row;
      wr_entry.col      = req_key_col;
      wr_entry.scan     = scan_ff;
      wr_entry.pressed  = req_pressed;
      wr_entry.modpress = req_pressed && req_is_modifier;
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      off_in        = off_ff;
      glen_in       = glen_ff;
      gscan_in      = gscan_ff;
      pass_in       = pass_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      wr_en         = 1'b0;
      strobe_in     = 1'b0;
      kind_in       = KIND_DECISION;
      deferred_in   = 1'b0;
      overflow_in   = 1'b0;
      row_in        = '0;
      col_in        = '0;
      pressed_in    = 1'b0;
      last_in       = 1'b0;

      if (cmd.key_ev) begin
         strobe_in   = 1'b1;
         deferred_in = defer;
         overflow_in = defer && full;
         last_in     = 1'b1;
         if (defer && !full) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.tick) begin
         scan_in = scan_ff + SCAN_W'(1);
         off_in  = '0;
         pass_in = 1'b0;
         if (!req_link_is_usb) begin
            head_in  = '0;
            count_in = '0;
         end
      end

      if (cmd.close_pass) begin
         glen_in = off_ff;
         off_in  = '0;
         pass_in = 1'b1;
      end

      if (cmd.close_group) begin
         count_in = count_ff - glen_ff;
         head_in  = stat.rest_empty ? '0 : gh_addr;
         off_in   = '0;
         pass_in  = 1'b0;
      end

      if (cmd.eval) begin
         if (!pass_ff && (off_ff == '0)) begin
            gscan_in = rd_ff.scan;
         end
         off_in = off_ff + CW'(1);
         if (rd_ff.modpress == !pass_ff) begin
            // hold the new entry, release the previous one
            if (pend_valid_ff) begin
               strobe_in  = 1'b1;
               kind_in    = KIND_REPLAY;
               row_in     = pend_ff.row;
               col_in     = pend_ff.col;
               pressed_in = pend_ff.pressed;
            end
            pend_in       = rd_ff;
            pend_valid_in = 1'b1;
         end
      end

      if (cmd.flush) begin
         strobe_in     = 1'b1;
         kind_in       = KIND_REPLAY;
         row_in        = pend_ff.row;
         col_in        = pend_ff.col;
         pressed_in    = pend_ff.pressed;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         scan_ff       <= '0;
         off_ff        <= '0;
         pass_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         off_ff        <= off_in;
         pass_ff       <= pass_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      glen_ff     <= glen_in;
      gscan_ff    <= gscan_in;
      pend_ff     <= pend_in;
      kind_ff     <= kind_in;
      deferred_ff <= deferred_in;
      overflow_ff <= overflow_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      pressed_ff  <= pressed_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_deferred     = deferred_ff;
   assign rsp_overflow     = overflow_ff;
   assign rsp_wake_request = deferred_ff;
   assign rsp_out_row      = row_ff;
   assign rsp_out_col      = col_ff;
   assign rsp_out_pressed  = pressed_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== hw/rtl/wake_event_hold_and_replay.sv =====
// Channel   Ports                     Beat taken when
// -------   -----------------------   ------------------------------------
// request   start, busy, req_*        rising edge with start high, busy low
// result    rsp_strobe, rsp_*         rising edge ending the strobe cycle
//
// Key event: its decision beat shows on the cycle after it is taken;
//   busy stays low, so key events can arrive back to back.
// Scan tick that replays: busy stays high while it walks N held events in
//   G scan groups through the single read port of the event ring (a read
//   and an evaluate step per entry in each of the two passes per group, one
//   closing step per pass, one more where a group ends at a scan break, and
//   one flush step). The final beat shows in the same cycle as busy falls.
//   Ticks that do not replay leave busy low and give no beat.
// Reset clears head, count, scan number and the sequencer; the ring itself is
//   not cleared, and entries are only evaluated inside the stored count.
// The receiver cannot stall: every rsp_strobe cycle is one delivered beat.
module wake_event_hold_and_replay #(
   parameter int unsigned QUEUE_DEPTH = wehr_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [wehr_pkg::ROW_W-1:0]   req_key_row,
   input  logic [wehr_pkg::COL_W-1:0]   req_key_col,
   input  logic                         req_pressed,
   input  logic                         req_is_modifier,
   input  logic                         req_link_is_usb,
   input  logic                         req_host_ready,
   output logic                         rsp_strobe,
   output logic                         rsp_kind,
   output logic                         rsp_deferred,
   output logic                         rsp_overflow,
   output logic                         rsp_wake_request,
   output logic [wehr_pkg::ROW_W-1:0]   rsp_out_row,
   output logic [wehr_pkg::COL_W-1:0]   rsp_out_col,
   output logic                         rsp_out_pressed,
   output logic                         rsp_last
);
   import wehr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence key decisions, ticks and the two-pass group replay
   wehr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_opcode      (req_opcode),
      .req_link_is_usb (req_link_is_usb),
      .req_host_ready  (req_host_ready),
      .stat            (stat),
      .cmd             (cmd),
      .busy            (busy)
   );

   // hold the ring, pointers, scan number and the result register; each
   // qualifying replay entry is held back until the next, so the last can carry rsp_last
   wehr_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_key_row      (req_key_row),
      .req_key_col      (req_key_col),
      .req_pressed      (req_pressed),
      .req_is_modifier  (req_is_modifier),
      .req_link_is_usb  (req_link_is_usb),
      .req_host_ready   (req_host_ready),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_deferred     (rsp_deferred),
      .rsp_overflow     (rsp_overflow),
      .rsp_wake_request (rsp_wake_request),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_pressed  (rsp_out_pressed),
      .rsp_last         (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a taken key event yields its decision beat on the next cycle
   a_key_decision: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_KEY)
      |=> rsp_strobe && (rsp_kind == KIND_DECISION) && rsp_last)
      else $error("key event without a decision beat");

   // the final replay beat arrives exactly as the sequencer returns to idle
   a_replay_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == KIND_REPLAY) && rsp_last |-> !busy)
      else $error("final replay beat while still busy");

   // no replay beat outside a busy period, except the final one
   a_replay_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == KIND_REPLAY) && !rsp_last |-> busy)
      else $error("replay beat outside a replay");

   // a replay beat never carries decision flags
   a_replay_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_kind == KIND_REPLAY)
      |-> !rsp_deferred && !rsp_overflow && !rsp_wake_request)
      else $error("replay beat with decision flags");
`endif

endmodule

// ===== bench/tb_wake_event_hold_and_replay.sv =====
module tb_wake_event_hold_and_replay;
   timeunit 1ns;
   timeprecision 1ps;

   import wehr_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   // leave a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT     = 1000000;
   // longest replay is a full ring of 32 held events in 32 scan groups
   localparam int TAIL_CYCLES     = 300;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int MAX_SHOWN       = 10;
   localparam int DIR_ROWS        = 22;

   // one request beat, laid out like the req_* ports
   typedef struct packed {
      logic             op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             pressed;
      logic             modifier;
      logic             usb;
      logic             ready;
   } key_req_type;

   // one result beat, laid out like the rsp_* ports
   typedef struct packed {
      logic             kind;
      logic             deferred;
      logic             overflow;
      logic             wake;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             pressed;
      logic             last;
   } result_beat_type;

   // directed row: a request, a repeat count, and an optional typed-in decision
   typedef struct packed {
      key_req_type req;
      logic [5:0]  reps;
      logic        typed;
      logic        exp_deferred;
      logic        exp_overflow;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_opcode      = OP_KEY;
   logic [ROW_W-1:0] req_key_row     = '0;
   logic [COL_W-1:0] req_key_col     = '0;
   logic             req_pressed     = 1'b0;
   logic             req_is_modifier = 1'b0;
   logic             req_link_is_usb = 1'b0;
   logic             req_host_ready  = 1'b0;
   logic             rsp_strobe;
   logic             rsp_kind;
   logic             rsp_deferred;
   logic             rsp_overflow;
   logic             rsp_wake_request;
   logic [ROW_W-1:0] rsp_out_row;
   logic [COL_W-1:0] rsp_out_col;
   logic             rsp_out_pressed;
   logic             rsp_last;

   wake_event_hold_and_replay #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_key_row     (req_key_row),
      .req_key_col     (req_key_col),
      .req_pressed     (req_pressed),
      .req_is_modifier (req_is_modifier),
      .req_link_is_usb (req_link_is_usb),
      .req_host_ready  (req_host_ready),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_deferred    (rsp_deferred),
      .rsp_overflow    (rsp_overflow),
      .rsp_wake_request(rsp_wake_request),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_pressed (rsp_out_pressed),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the held-event ring
   // ---------------------------------------------------------------------
   entry_type          held_ring [DEPTH];
   int                 held_head  = 0;
   int                 held_count = 0;
   logic [SCAN_W-1:0]  scan_now   = '0;

   result_beat_type    expected_beats [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 items_sent  = 0;
   int                 idle_pct    = 0;

   // Directed table. Decisions are typed in where obvious; replay ticks are
   // left to the predictor. The ring-filling row repeats with varied content.
   stim_row_type directed_rows [DIR_ROWS] = '{
      // tick right after reset, nothing held
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      // non-USB link, USB with ready host, non-USB with ready host: never deferred
      '{'{OP_KEY,  3'd0, 5'd0,  1'b0, 1'b0, 1'b0, 1'b0}, 6'd1,  1'b1, 1'b0, 1'b0},
      '{'{OP_KEY,  3'd7, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      '{'{OP_KEY,  3'd7, 5'd31, 1'b1, 1'b1, 1'b0, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      // first group: modifier press, modifier release, plain press
      '{'{OP_KEY,  3'd7, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_KEY,  3'd0, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_KEY,  3'd3, 5'd17, 1'b1, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      // host still not ready: advance the scan, no beat
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b0, 1'b0},
      // second group
      '{'{OP_KEY,  3'd5, 5'd9,  1'b1, 1'b1, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_KEY,  3'd1, 5'd30, 1'b0, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      // replay both groups
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b1}, 6'd1,  1'b0, 1'b0, 1'b0},
      // hold one, then drop it with a non-USB tick
      '{'{OP_KEY,  3'd2, 5'd4,  1'b1, 1'b1, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b0, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      // fill the ring, then overflow it
      '{'{OP_KEY,  3'd6, 5'd21, 1'b1, 1'b1, 1'b1, 1'b0}, 6'd32, 1'b1, 1'b1, 1'b0},
      '{'{OP_KEY,  3'd4, 5'd12, 1'b0, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b1},
      '{'{OP_KEY,  3'd4, 5'd12, 1'b1, 1'b1, 1'b1, 1'b1}, 6'd1,  1'b1, 1'b0, 1'b0},
      // replay a full ring in one go
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b1}, 6'd1,  1'b0, 1'b0, 1'b0},
      // head back at zero: two groups of one
      '{'{OP_KEY,  3'd0, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b0, 1'b0},
      '{'{OP_KEY,  3'd7, 5'd0,  1'b1, 1'b0, 1'b1, 1'b0}, 6'd1,  1'b1, 1'b1, 1'b0},
      '{'{OP_TICK, 3'd0, 5'd0,  1'b0, 1'b0, 1'b1, 1'b1}, 6'd1,  1'b0, 1'b0, 1'b0}
   };

   // ---------------------------------------------------------------------
   // Predictor: hold a deferred key event, or replay or drop the held groups
   // on a tick, and append the beats this request causes to expected_beats.
   // ---------------------------------------------------------------------
   function void hold_or_replay(input key_req_type it);
      result_beat_type   b;
      result_beat_type   pend;
      bit                have_pend;
      entry_type         e;
      logic [SCAN_W-1:0] gscan;
      int                glen;
      b         = '0;
      pend      = '0;
      have_pend = 1'b0;
      if (it.op == OP_KEY) begin
         b.kind = KIND_DECISION;
         b.last = 1'b1;
         if (it.usb && !it.ready) begin
            // swallowed either way; stored only while there is room
            b.deferred = 1'b1;
            b.wake     = 1'b1;
            if (held_count < DEPTH) begin
               e.row      = it.row;
               e.col      = it.col;
               e.scan     = scan_now;
               e.pressed  = it.pressed;
               e.modpress = it.pressed & it.modifier;
               held_ring[(held_head + held_count) % DEPTH] = e;
               held_count++;
            end else begin
               b.overflow = 1'b1;
            end
         end
         expected_beats.push_back(b);
         return;
      end
      scan_now = scan_now + 1;
      if (held_count == 0) return;
      if (!it.usb) begin
         // drop everything held
         held_head  = 0;
         held_count = 0;
         return;
      end
      if (!it.ready) return;
      while (held_count > 0) begin
         // a group is the run of entries sharing the head's scan number
         gscan = held_ring[held_head].scan;
         glen  = 0;
         while (glen < held_count && held_ring[(held_head + glen) % DEPTH].scan == gscan)
            glen++;
         // modifier presses first, then the rest, both in queue order
         for (int pass = 0; pass < 2; pass++) begin
            for (int off = 0; off < glen; off++) begin
               e = held_ring[(held_head + off) % DEPTH];
               if (e.modpress == (pass == 0)) begin
                  if (have_pend) expected_beats.push_back(pend);
                  pend         = '0;
                  pend.kind    = KIND_REPLAY;
                  pend.row     = e.row;
                  pend.col     = e.col;
                  pend.pressed = e.pressed;
                  have_pend    = 1'b1;
               end
            end
         end
         held_head  = (held_head + glen) % DEPTH;
         held_count = held_count - glen;
      end
      held_head = 0;
      // mark the final replayed beat
      if (have_pend) begin
         pend.last = 1'b1;
         expected_beats.push_back(pend);
      end
   endfunction

   function string beat_text(input result_beat_type b);
      return $sformatf("kind=%0d def=%0d ovf=%0d wake=%0d row=%0d col=%0d pr=%0d last=%0d",
                       b.kind, b.deferred, b.overflow, b.wake, b.row, b.col,
                       b.pressed, b.last);
   endfunction

   function bit coin();
      return $urandom_range(1) != 0;
   endfunction

   // random row, column, press and modifier; opcode and link state given
   function key_req_type make_item(input logic op, input logic usb, input logic ready);
      key_req_type it;
      logic [31:0] r;
      r           = $urandom;
      it.op       = op;
      it.row      = r[ROW_W-1:0];
      it.col      = r[ROW_W+COL_W-1:ROW_W];
      it.pressed  = r[8];
      it.modifier = r[9];
      it.usb      = usb;
      it.ready    = ready;
      return it;
   endfunction

   task automatic log_failure(input string msg);
      error_count++;
      if (error_count <= MAX_SHOWN) $display("%0t ERROR: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------
   // Request side. Call at a rising edge: present the beat, hold it until
   // the edge that takes it, then predict. Start is left high; the caller
   // either presents the next beat or lowers start in pace/drain.
   // ---------------------------------------------------------------------
   task automatic send_beat(input key_req_type it, input bit typed,
                            input logic exp_def, input logic exp_ovf);
      int              n0;
      result_beat_type t;
      start           <= 1'b1;
      req_opcode      <= it.op;
      req_key_row     <= it.row;
      req_key_col     <= it.col;
      req_pressed     <= it.pressed;
      req_is_modifier <= it.modifier;
      req_link_is_usb <= it.usb;
      req_host_ready  <= it.ready;
      do @(posedge clock); while (busy !== 1'b0);
      n0 = expected_beats.size();
      hold_or_replay(it);
      if (typed) begin
         // swap the predicted beats for the typed-in decision
         while (expected_beats.size() > n0) void'(expected_beats.pop_back());
         if (it.op == OP_KEY) begin
            t          = '0;
            t.kind     = KIND_DECISION;
            t.deferred = exp_def;
            t.overflow = exp_ovf;
            t.wake     = exp_def;
            t.last     = 1'b1;
            expected_beats.push_back(t);
         end
      end
      items_sent++;
   endtask

   // idle the request side for a random stretch, per the phase's idle rate
   task automatic pace();
      int n;
      n = 0;
      while (n < 16 && $urandom_range(99) < idle_pct) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every expected beat is in, then let the block settle
   task automatic drain();
      start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_item(input key_req_type it);
      send_beat(it, 1'b0, 1'b0, 1'b0);
      pace();
   endtask

   // Well-formed session: a few groups of deferred key events separated by
   // not-ready ticks, with an occasional overflow burst and stray events,
   // closed mostly by a replay tick.
   task automatic run_session();
      int groups;
      int k;
      int pick;
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
         k = ($urandom_range(7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
         repeat (k) begin
            if ($urandom_range(9) == 0) begin
               // stray event that must pass straight through
               if (coin()) push_item(make_item(OP_KEY, 1'b0, coin()));
               else push_item(make_item(OP_KEY, 1'b1, 1'b1));
            end else begin
               push_item(make_item(OP_KEY, 1'b1, 1'b0));
            end
         end
         if (g < groups - 1) push_item(make_item(OP_TICK, 1'b1, 1'b0));
      end
      pick = $urandom_range(9);
      if (pick < 7) push_item(make_item(OP_TICK, 1'b1, 1'b1));
      else if (pick < 9) push_item(make_item(OP_TICK, 1'b0, coin()));
      else push_item(make_item(OP_TICK, 1'b1, 1'b0));
   endtask

   // Broken session: hold a few, drop them with a non-USB tick, then try a
   // replay on the empty ring.
   task automatic run_dropped_session();
      repeat ($urandom_range(1, 5)) push_item(make_item(OP_KEY, 1'b1, 1'b0));
      push_item(make_item(OP_TICK, 1'b0, coin()));
      push_item(make_item(OP_TICK, 1'b1, 1'b1));
   endtask

   // ---------------------------------------------------------------------
   // Result side: the receiver cannot stall, so every strobe is a beat.
   // Compare it against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_beat_type got;
      result_beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = '{rsp_kind, rsp_deferred, rsp_overflow, rsp_wake_request,
                 rsp_out_row, rsp_out_col, rsp_out_pressed, rsp_last};
         if (expected_beats.size() == 0) begin
            log_failure({"unexpected beat: ", beat_text(got)});
         end else begin
            want = expected_beats.pop_front();
            if (got !== want)
               log_failure({"mismatch: expected ", beat_text(want),
                            " got ", beat_text(got)});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type r;
      key_req_type  it;
      int           pct_list [3];
      int           target;
      int           pick;
      pct_list = '{0, 60, 32};

      // hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, back to back
      idle_pct = 0;
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         for (int k = 0; k < r.reps; k++) begin
            // vary repeated rows so the replay order is exercised
            it          = r.req;
            it.col      = it.col ^ k[COL_W-1:0];
            it.modifier = it.modifier ^ k[0];
            it.pressed  = it.pressed ^ k[1];
            send_beat(it, r.typed, r.exp_deferred, r.exp_overflow);
         end
      end
      drain();

      // random phases; drain between them so the sender waits out every beat
      foreach (pct_list[p]) begin
         idle_pct = pct_list[p];
         target   = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               run_session();
            end else if (pick < 85) begin
               run_dropped_session();
            end else begin
               // noise: any opcode, any link state
               push_item(make_item(coin(), coin(), coin()));
            end
         end
         drain();
      end

      // let any late beat show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0) log_failure("expected beats left over");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== wake_event_hold_and_replay.f =====
hw/rtl/wehr_pkg.sv
hw/rtl/wehr_ctrl.sv
hw/rtl/wehr_datapath.sv
hw/rtl/wake_event_hold_and_replay.sv
bench/tb_wake_event_hold_and_replay.sv
